// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/lrd_pkg.sv =====
// Types and constants of the light-sensor report decoder.
package lrd_pkg;

  // Report id that carries timecodes
  localparam logic [7:0]  DECODED_ID = 8'd40;
  // Channel-byte bits that stop the report
  localparam logic [7:0]  STOP_BITS  = 8'h0A;
  // Half of the 24-bit time range
  localparam logic [23:0] HALF_RANGE = 24'h800000;

  // Record kinds
  localparam logic KIND_SYNC  = 1'b0;
  localparam logic KIND_SWEEP = 1'b1;

  // One input beat
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_report;
    logic [31:0] inertial_time;
  } rpt_t;

  // One result beat
  typedef struct packed {
    logic        record_kind;
    logic [31:0] timestamp;
    logic [3:0]  channel;
    logic        ootx_bit;
    logic        g_bit;
    logic [4:0]  sensor_index;
    logic        half_clock;
  } rec_t;

endpackage

// ===== hdl/lrd_widen.sv =====
// Widens a 24-bit time to 32 bits against a reference time.
module lrd_widen (
  input  logic [23:0] t,
  input  logic [31:0] ref_time,
  output logic [31:0] widened
);
  import lrd_pkg::*;

  logic [7:0]  up;
  logic [23:0] lo;
  logic [23:0] lo_minus_t;
  logic [23:0] t_minus_lo;
  logic [7:0]  up_next;

  assign up         = ref_time[31:24];
  assign lo         = ref_time[23:0];
  assign lo_minus_t = lo - t;
  assign t_minus_lo = t - lo;

  // Half-range wrap: step the upper byte forward or back
  always_comb begin
    up_next = up;
    if (lo > t && lo_minus_t > HALF_RANGE) begin
      up_next = up + 8'd1;
    end else if (lo < t && t_minus_lo > HALF_RANGE && up != 8'd0) begin
      up_next = up - 8'd1;
    end
  end

  assign widened = {up_next, t};

endmodule

// ===== hdl/lightcap_report_decoder_core.sv =====
// Top level of the light-sensor report decoder.
//
//  channel | direction | payload | handshake
//  rpt     | in        | rpt_t   | rpt_valid / rpt_ready
//  rec     | out       | rec_t   | rec_valid / rec_ready
//
// One byte is taken per cycle while the result register is not stalled; a
// completed timecode word shows on rec in the cycle after the beat that completes it.
// Throughput is set by the single result register: rpt_ready is high when
// that register is empty or is being drained in the same cycle.
// rst (synchronous) returns the parser to expecting a report id, clears the
// channel nibble and empties the result register.
module lightcap_report_decoder_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          rpt_valid,
  output logic          rpt_ready,
  input  lrd_pkg::rpt_t rpt,
  output logic          rec_valid,
  input  logic          rec_ready,
  output lrd_pkg::rec_t rec
);
  import lrd_pkg::*;

  typedef enum logic [1:0] {
    PH_ID,
    PH_LEN,
    PH_PAYLOAD,
    PH_IDLE
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  element_offset, element_offset_next;
  logic [3:0]  current_channel, current_channel_next;
  logic        channel_known, channel_known_next;
  logic        report_stopped, report_stopped_next;
  logic [23:0] word_bytes, word_bytes_next;
  logic [1:0]  word_count, word_count_next;

  logic        take;
  logic        emit;
  logic [31:0] word;
  logic [23:0] time_raw;
  logic [31:0] time_wide;
  rec_t        rec_next;

  assign rpt_ready = !rec_valid || rec_ready;
  assign take      = rpt_valid && rpt_ready;
  assign word      = {rpt.data_byte, word_bytes};

  // Time field position depends on the record kind
  assign time_raw = word[1] ? word[26:3] : word[25:2];

  lrd_widen u_widen (
    .t        (time_raw),
    .ref_time (rpt.inertial_time),
    .widened  (time_wide)
  );

  // Parser next state
  always_comb begin
    phase_next           = phase;
    payload_length_next  = payload_length;
    element_offset_next  = element_offset;
    current_channel_next = current_channel;
    channel_known_next   = channel_known;
    report_stopped_next  = report_stopped;
    word_bytes_next      = word_bytes;
    word_count_next      = word_count;
    emit                 = 1'b0;
    if (rpt.start_of_report || phase == PH_ID) begin
      payload_length_next = 8'd0;
      element_offset_next = 8'd0;
      channel_known_next  = 1'b0;
      report_stopped_next = 1'b0;
      word_bytes_next     = 24'd0;
      word_count_next     = 2'd0;
      phase_next          = (rpt.data_byte == DECODED_ID) ? PH_LEN : PH_IDLE;
    end else begin
      case (phase)
        PH_LEN: begin
          payload_length_next = rpt.data_byte;
          element_offset_next = 8'd0;
          phase_next          = (rpt.data_byte == 8'd0) ? PH_IDLE : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          element_offset_next = element_offset + 8'd1;
          if (!report_stopped) begin
            case (word_count)
              2'd0: begin
                if (rpt.data_byte[0]) begin
                  if ((rpt.data_byte & STOP_BITS) != 8'd0) begin
                    report_stopped_next = 1'b1;
                  end else begin
                    current_channel_next = rpt.data_byte[7:4];
                    channel_known_next   = 1'b1;
                  end
                end else begin
                  word_bytes_next = {16'd0, rpt.data_byte};
                  word_count_next = 2'd1;
                end
              end
              2'd1: begin
                word_bytes_next = {word_bytes[23:16], rpt.data_byte, word_bytes[7:0]};
                word_count_next = 2'd2;
              end
              2'd2: begin
                word_bytes_next = {rpt.data_byte, word_bytes[15:0]};
                word_count_next = 2'd3;
              end
              default: begin
                word_bytes_next = 24'd0;
                word_count_next = 2'd0;
                emit            = channel_known;
              end
            endcase
          end
          // Payload end drops any partial word
          if (element_offset_next >= payload_length) begin
            word_bytes_next = 24'd0;
            word_count_next = 2'd0;
            phase_next      = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result fields
  always_comb begin
    rec_next.timestamp = time_wide;
    rec_next.channel   = current_channel;
    if (word[1]) begin
      rec_next.record_kind  = KIND_SWEEP;
      rec_next.ootx_bit     = 1'b0;
      rec_next.g_bit        = 1'b0;
      rec_next.sensor_index = word[31:27];
      rec_next.half_clock   = word[2];
    end else begin
      rec_next.record_kind  = KIND_SYNC;
      rec_next.ootx_bit     = word[26];
      rec_next.g_bit        = word[27];
      rec_next.sensor_index = 5'd0;
      rec_next.half_clock   = 1'b0;
    end
  end

  // Parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_ID;
      payload_length  <= 8'd0;
      element_offset  <= 8'd0;
      current_channel <= 4'd0;
      channel_known   <= 1'b0;
      report_stopped  <= 1'b0;
      word_bytes      <= 24'd0;
      word_count      <= 2'd0;
      rec_valid       <= 1'b0;
    end else begin
      if (take) begin
        phase           <= phase_next;
        payload_length  <= payload_length_next;
        element_offset  <= element_offset_next;
        current_channel <= current_channel_next;
        channel_known   <= channel_known_next;
        report_stopped  <= report_stopped_next;
        word_bytes      <= word_bytes_next;
        word_count      <= word_count_next;
      end
      // Load on an emitting beat, clear once drained
      if (take && emit) begin
        rec_valid <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (take && emit) begin
      rec <= rec_next;
    end
  end

endmodule

// ===== hdl/lrd_checker.sv =====
// Port-level checker for the report decoder, bound to the top level.
`include "assert_macros.svh"

module lrd_checker (
  input logic          clk,
  input logic          rst,
  input logic          rpt_ready,
  input logic          rec_valid,
  input logic          rec_ready,
  input lrd_pkg::rec_t rec
);
  import lrd_pkg::*;

  // A stalled result beat stays and holds its payload
  `ASSERT_NEXT(a_rec_hold, clk, rst, rec_valid && !rec_ready, rec_valid)
  `ASSERT_NEXT(a_rec_stable, clk, rst, rec_valid && !rec_ready, $stable(rec))
  // An empty result register never blocks input
  `ASSERT_IMPLY(a_ready_empty, clk, rst, !rec_valid, rpt_ready)
  // Fields of the other record kind read zero
  `ASSERT_IMPLY(a_sync_zero, clk, rst, rec_valid && rec.record_kind == KIND_SYNC,
    rec.sensor_index == 5'd0 && rec.half_clock == 1'b0)
  `ASSERT_IMPLY(a_sweep_zero, clk, rst, rec_valid && rec.record_kind == KIND_SWEEP,
    rec.ootx_bit == 1'b0 && rec.g_bit == 1'b0)

endmodule

bind lightcap_report_decoder_core lrd_checker u_lrd_checker (
  .clk       (clk),
  .rst       (rst),
  .rpt_ready (rpt_ready),
  .rec_valid (rec_valid),
  .rec_ready (rec_ready),
  .rec       (rec)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the light-sensor report decoder: byte stimulus, record prediction.
`timescale 1ns / 100ps

module tb_top;
  import lrd_pkg::*;

  // Parser phases of the record predictor
  typedef enum logic [1:0] {
    PH_REPORT_ID,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_DONE
  } parse_phase_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int RANDOM_ITEMS   = 700;
  localparam int STEADY_ITEMS   = 200;
  localparam int SETTLE_CYCLES  = 4;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  rpt_valid = 1'b0;
  logic  rpt_ready;
  rpt_t  rpt = '0;
  logic  rec_valid;
  logic  rec_ready = 1'b0;
  rec_t  rec;

  // Bytes queued for the driver, records still owed by the block
  rpt_t  beat_q[$];
  rec_t  pending_records[$];
  int    beats_outstanding = 0;
  int    items_sent = 0;
  int    error_count = 0;
  int    idle_cycles = 0;
  int    holdoff_req = 0;
  int    holdoff_left = 0;
  bit    steady = 1'b0;

  // Predictor state
  parse_phase_t pr_phase = PH_REPORT_ID;
  logic [7:0]   pr_length = '0;
  logic [7:0]   pr_offset = '0;
  logic [3:0]   pr_channel = '0;
  logic         pr_channel_known = 1'b0;
  logic         pr_stopped = 1'b0;
  logic [23:0]  pr_word = '0;
  logic [1:0]   pr_word_count = '0;

  lightcap_report_decoder_core DUT (
    .clk       (clk),
    .rst       (rst),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt       (rpt),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Widen a 24-bit time against the reference, wrapping on half-range moves
  function automatic logic [31:0] extend_time(input logic [23:0] t,
                                              input logic [31:0] ref_time);
    logic [7:0]  upper;
    logic [23:0] lower;
    upper = ref_time[31:24];
    lower = ref_time[23:0];
    if (lower > t && lower - t > HALF_RANGE) begin
      upper = upper + 8'd1;
    end else if (lower < t && t - lower > HALF_RANGE && upper != 8'd0) begin
      upper = upper - 8'd1;
    end
    return {upper, t};
  endfunction

  // Advance the parser by one accepted byte; queue the record it completes
  task automatic decode_byte(input rpt_t beat);
    logic [7:0]  b;
    logic [31:0] w;
    rec_t        r;
    b = beat.data_byte;
    if (beat.start_of_report || pr_phase == PH_REPORT_ID) begin
      pr_length        = '0;
      pr_offset        = '0;
      pr_channel_known = 1'b0;
      pr_stopped       = 1'b0;
      pr_word          = '0;
      pr_word_count    = '0;
      pr_phase         = (b == DECODED_ID) ? PH_LENGTH : PH_DONE;
    end else if (pr_phase == PH_LENGTH) begin
      pr_length = b;
      pr_offset = '0;
      pr_phase  = (b == 8'd0) ? PH_DONE : PH_PAYLOAD;
    end else if (pr_phase == PH_PAYLOAD) begin
      pr_offset = pr_offset + 8'd1;
      if (!pr_stopped) begin
        if (pr_word_count == 2'd0) begin
          if (b[0]) begin
            if ((b & STOP_BITS) != 8'd0) begin
              pr_stopped = 1'b1;
            end else begin
              pr_channel       = b[7:4];
              pr_channel_known = 1'b1;
            end
          end else begin
            pr_word       = {16'd0, b};
            pr_word_count = 2'd1;
          end
        end else if (pr_word_count < 2'd3) begin
          pr_word[8*pr_word_count +: 8] = b;
          pr_word_count = pr_word_count + 2'd1;
        end else begin
          w             = {b, pr_word};
          pr_word       = '0;
          pr_word_count = '0;
          if (pr_channel_known) begin
            r = '0;
            r.channel = pr_channel;
            if (!w[1]) begin
              r.record_kind = KIND_SYNC;
              r.timestamp   = extend_time(w[25:2], beat.inertial_time);
              r.ootx_bit    = w[26];
              r.g_bit       = w[27];
            end else begin
              r.record_kind  = KIND_SWEEP;
              r.timestamp    = extend_time(w[26:3], beat.inertial_time);
              r.sensor_index = w[31:27];
              r.half_clock   = w[2];
            end
            pending_records.push_back(r);
          end
        end
      end
      if (pr_offset >= pr_length) begin
        pr_word       = '0;
        pr_word_count = '0;
        pr_phase      = PH_DONE;
      end
    end
  endtask

  // Byte driver: presents queued beats, predicts on each accepted one
  always @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else begin
      if (rpt_valid && rpt_ready) begin
        decode_byte(rpt);
        beats_outstanding--;
      end
      if (!rpt_valid || rpt_ready) begin
        if (beat_q.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
          rpt       <= beat_q.pop_front();
          rpt_valid <= 1'b1;
        end else begin
          rpt_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Record sink: random stalls, long hold-off on request, field checks
  always @(posedge clk) begin
    rec_t want;
    if (rst) begin
      rec_ready <= 1'b0;
    end else begin
      if (rec_valid && rec_ready) begin
        if (pending_records.size() == 0) begin
          $display("%0t: unexpected record: expected none, actual %h", $time, rec);
          error_count++;
        end else begin
          want = pending_records.pop_front();
          compare_field("record_kind", want.record_kind, rec.record_kind);
          compare_field("timestamp", want.timestamp, rec.timestamp);
          compare_field("channel", want.channel, rec.channel);
          compare_field("ootx_bit", want.ootx_bit, rec.ootx_bit);
          compare_field("g_bit", want.g_bit, rec.g_bit);
          compare_field("sensor_index", want.sensor_index, rec.sensor_index);
          compare_field("half_clock", want.half_clock, rec.half_clock);
        end
      end
      if (holdoff_req != 0) begin
        holdoff_left = holdoff_req;
        holdoff_req  = 0;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        rec_ready <= 1'b0;
      end else begin
        rec_ready <= steady || $urandom_range(99) >= 11;
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (rpt_valid && rpt_ready) || (rec_valid && rec_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Upper byte biased toward the wrap extremes
  function automatic logic [31:0] pick_ref();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: v[31:24] = 8'h00;
      1: v[31:24] = 8'hFF;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_beat(input logic [7:0] data, input logic start,
                           input logic [31:0] ref_time);
    rpt_t beat;
    while (beat_q.size() >= 4) @(posedge clk);
    beat.data_byte       = data;
    beat.start_of_report = start;
    beat.inertial_time   = ref_time;
    beats_outstanding++;
    items_sent++;
    beat_q.push_back(beat);
  endtask

  // Timecode word, little-endian
  task automatic send_word(input logic [31:0] w, input logic [31:0] ref_time);
    for (int k = 0; k < 4; k++) begin
      send_beat(w[8*k +: 8], 1'b0, ref_time);
    end
  endtask

  // Wait until every byte is taken and every record has come back
  task automatic drain();
    while (beats_outstanding != 0 || pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Id byte right after reset without a start mark; sync record, upper wraps to zero
  task automatic test_unmarked_first_byte();
    send_beat(DECODED_ID, 1'b0, 32'h0);
    send_beat(8'd5, 1'b0, 32'h0);
    send_beat(8'hF1, 1'b0, 32'h0);
    send_word(32'h0C00_0000, 32'hFFFF_FFFF);
  endtask

  // Start mark in mid-payload drops the partial word
  task automatic test_restart_mid_report();
    send_beat(DECODED_ID, 1'b1, 32'h0);
    send_beat(8'd3, 1'b0, 32'h0);
    send_beat(8'h21, 1'b0, 32'h0);
    send_beat(8'h00, 1'b0, 32'h0);
  endtask

  // Sweep record with downward wrap, then a stop byte and an ignored tail
  task automatic test_sweep_and_stop();
    send_beat(DECODED_ID, 1'b1, 32'h0);
    send_beat(8'd7, 1'b0, 32'h0);
    send_beat(8'h01, 1'b0, 32'h0);
    send_word(32'hFFFF_FFFE, 32'h8000_0000);
    send_beat(8'h0B, 1'b0, 32'h0);
    send_beat(8'h00, 1'b0, 32'h0);
  endtask

  // Word before any channel byte, then a word cut off by the payload end
  task automatic test_no_channel_and_truncation();
    send_beat(DECODED_ID, 1'b1, 32'h0);
    send_beat(8'd6, 1'b0, 32'h0);
    send_word(32'h0, 32'h0);
    send_beat(8'h11, 1'b0, 32'h0);
    send_beat(8'h00, 1'b0, 32'h0);
  endtask

  // Other report id, then zero length with a byte past the end
  task automatic test_ignored_reports();
    send_beat(DECODED_ID + 8'd1, 1'b1, 32'h0);
    send_beat(8'd1, 1'b0, 32'h0);
    send_beat(8'h01, 1'b0, 32'h0);
    send_beat(DECODED_ID, 1'b1, 32'h0);
    send_beat(8'd0, 1'b0, 32'h0);
    send_beat(8'h01, 1'b0, 32'h0);
  endtask

  // Record sink held off while a long report keeps coming
  task automatic test_backpressure();
    logic [31:0] w;
    holdoff_req = HOLDOFF_CYCLES;
    send_beat(DECODED_ID, 1'b1, pick_ref());
    send_beat(8'd61, 1'b0, pick_ref());
    send_beat(8'h71, 1'b0, pick_ref());
    repeat (15) begin
      w    = $urandom;
      w[0] = 1'b0;
      send_word(w, pick_ref());
    end
  endtask

  // One report: mostly well-formed with random content, some noise
  task automatic send_random_report();
    int          kind;
    int          len;
    int          limit;
    int          sent;
    int          pick;
    logic [7:0]  b;
    logic [31:0] w;
    kind = $urandom_range(99);
    if (kind < 10) begin
      // noise: any id, loose bytes, stray start marks
      send_beat(8'($urandom), 1'b1, pick_ref());
      repeat ($urandom_range(6)) send_beat(8'($urandom), $urandom_range(9) == 0, pick_ref());
    end else begin
      if (kind < 14) begin
        len = 0;
      end else if (kind < 17) begin
        len = $urandom_range(41, 255);
      end else begin
        len = $urandom_range(1, 40);
      end
      // sometimes cut short by the next report, sometimes overrun
      pick = $urandom_range(9);
      if (pick == 0) begin
        limit = $urandom_range(len);
      end else if (pick == 1) begin
        limit = len + $urandom_range(1, 3);
      end else begin
        limit = len;
      end
      send_beat(DECODED_ID, 1'b1, pick_ref());
      send_beat(len[7:0], 1'b0, pick_ref());
      sent = 0;
      while (sent < limit) begin
        pick = $urandom_range(99);
        if ((sent == 0 && pick < 85) || (sent != 0 && pick < 20)) begin
          b    = 8'($urandom);
          b[3] = 1'b0;
          b[1] = 1'b0;
          b[0] = 1'b1;
          send_beat(b, 1'b0, pick_ref());
          sent++;
        end else if (pick < 23) begin
          b    = 8'($urandom);
          b[0] = 1'b1;
          if (!b[1] && !b[3]) b[3] = 1'b1;
          send_beat(b, 1'b0, pick_ref());
          sent++;
        end else if (pick < 28) begin
          send_beat(8'($urandom), 1'b0, pick_ref());
          sent++;
        end else begin
          w    = $urandom;
          w[0] = 1'b0;
          for (int k = 0; k < 4 && sent < limit; k++) begin
            send_beat(w[8*k +: 8], 1'b0, pick_ref());
            sent++;
          end
        end
      end
    end
  endtask

  task automatic test_random_reports();
    int base;
    base   = items_sent;
    steady = 1'b1;
    while (items_sent - base < RANDOM_ITEMS) begin
      steady = (items_sent - base < STEADY_ITEMS);
      send_random_report();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unmarked_first_byte();
    test_restart_mid_report();
    test_sweep_and_stop();
    test_no_channel_and_truncation();
    test_ignored_reports();
    drain();
    test_backpressure();
    drain();
    test_random_reports();
    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lrd_pkg.sv
hdl/lrd_widen.sv
hdl/lightcap_report_decoder_core.sv
hdl/lrd_checker.sv
bench/tb_top.sv
